// ===== hdl/kwtt_pkg.sv =====
// Shared types and constants for the keyed watchdog timeout table.
package kwtt_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic FUNC_CHECK   = 1'b0;
	localparam logic FUNC_REFRESH = 1'b1;

	typedef struct packed {
		logic        func;
		logic [63:0] serial;
		logic [31:0] now_ms;
		logic [31:0] timeout_ms;
		logic [15:0] limit_watts;
	} cmd_t;

	typedef struct packed {
		logic [63:0] expired_serial;
		logic [15:0] fallback_watts;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] deadline;
		logic [15:0] watts;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic match;
		logic free;
	} eval_t;

endpackage

// ===== hdl/kwtt_entry_eval.sv =====
// Per-entry evaluation: expiry test, key match and free-slot flag.
module kwtt_entry_eval (
	input  kwtt_pkg::cmd_t   command,
	input  kwtt_pkg::entry_t entry,
	input  logic             occupied,
	output kwtt_pkg::eval_t  flags
);

	logic [31:0] diff;

	// wrap-safe: expired when now - deadline is positive as a signed value
	assign diff        = command.now_ms - entry.deadline;
	assign flags.hit   = occupied && (diff != 32'd0) && !diff[31];
	assign flags.match = occupied && (entry.key == command.serial);
	assign flags.free  = !occupied;

endmodule

// ===== hdl/keyed_watchdog_timeout_table_unit.sv =====
// Keyed watchdog timeout table: top level with entry memory and scan sequencer.
//
// Usage: drive command and raise start; the item is taken at a clock edge where
// start is high and busy is low. func selects check or refresh.
// A refresh with a nonzero serial and timeout scans the entries (one memory read
// per entry), stops at the slot holding its serial, or else takes the lowest free
// slot, writing deadline now_ms + timeout_ms and the given watts. A full table
// drops it. Busy stays high for the scan, up to the slot with its serial, and for
// the entry write unless the table is full; an ignored refresh never raises busy.
// A check scans all entries from slot 0 and reports each expired entry on
// result, with strobe high for exactly one cycle; the entry is freed. At most
// MAX_RESULTS (8) results go out per item, the final one with last set. The
// sequencer holds one found entry back so that last can be decided, so the
// last result shows in the first cycle with busy low. A check keeps the block busy
// for its scan, one memory read per entry, plus pipeline fill and flush; the result
// cap can end the scan early. There is no stall from the receiver: results must be
// taken when strobed. Reset clears all valid bits and the sequencer at once; entry
// contents need no clearing.
module keyed_watchdog_timeout_table_unit #(
	parameter int NUM_ENTRIES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kwtt_pkg::cmd_t   command,
	output logic             strobe,
	output kwtt_pkg::rsp_t   result
);

	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t                     state_q;
	kwtt_pkg::cmd_t             cmd_q;
	kwtt_pkg::entry_t           entry_mem_q [NUM_ENTRIES];
	kwtt_pkg::entry_t           rd_data_s1;
	logic [NUM_ENTRIES-1:0]     valid_q;
	logic [CW-1:0]              rd_cnt_q;
	logic                       rd_en_s1;
	logic [IW-1:0]              idx_s1;
	logic [kwtt_pkg::CNT_W-1:0] cnt_q;
	logic                       pend_valid_q;
	logic [63:0]                pend_key_q;
	logic [15:0]                pend_watts_q;
	logic                       free_found_q;
	logic [IW-1:0]              free_idx_q;
	logic [IW-1:0]              tgt_q;
	logic                       strobe_q;
	kwtt_pkg::rsp_t             rsp_q;

	kwtt_pkg::eval_t flags;
	logic            is_check;
	logic            eval_go;
	logic            scan_end;
	logic            hit_go;
	logic            cap_full;
	logic            match_go;
	logic            issue;
	logic            ignore_refresh;

	kwtt_entry_eval u_eval (
		.command  (cmd_q),
		.entry    (rd_data_s1),
		.occupied (valid_q[idx_s1]),
		.flags    (flags)
	);

	assign is_check = (cmd_q.func == kwtt_pkg::FUNC_CHECK);
	assign eval_go  = (state_q == ST_SCAN) && rd_en_s1;
	assign scan_end = eval_go && (idx_s1 == IW'(NUM_ENTRIES - 1));
	assign hit_go   = eval_go && is_check && flags.hit;
	assign cap_full = hit_go && (cnt_q == kwtt_pkg::CNT_W'(kwtt_pkg::MAX_RESULTS - 1));
	assign match_go = eval_go && !is_check && flags.match;
	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < CW'(NUM_ENTRIES));

	assign ignore_refresh = (command.func == kwtt_pkg::FUNC_REFRESH) &&
		((command.serial == 64'd0) || (command.timeout_ms == 32'd0));

	// entry memory: one read port during scan, one write at the end of a refresh
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= entry_mem_q[rd_cnt_q[IW-1:0]];
		end
		if (state_q == ST_WRITE) begin
			entry_mem_q[tgt_q] <= '{key:      cmd_q.serial,
			                        deadline: cmd_q.now_ms + cmd_q.timeout_ms,
			                        watts:    cmd_q.limit_watts};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cmd_q <= command;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[IW-1:0];
		end
		if (hit_go) begin
			pend_key_q   <= rd_data_s1.key;
			pend_watts_q <= rd_data_s1.watts;
		end
		if (hit_go && pend_valid_q) begin
			rsp_q <= '{expired_serial: pend_key_q, fallback_watts: pend_watts_q, last: 1'b0};
		end else if ((state_q == ST_FLUSH) && pend_valid_q) begin
			rsp_q <= '{expired_serial: pend_key_q, fallback_watts: pend_watts_q, last: 1'b1};
		end
		if (eval_go && !is_check && flags.free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (match_go) begin
			tgt_q <= idx_s1;
		end else if (scan_end && !is_check) begin
			tgt_q <= free_found_q ? free_idx_q : idx_s1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			rd_en_s1     <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			free_found_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rd_en_s1 <= issue;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_cnt_q     <= '0;
					cnt_q        <= '0;
					free_found_q <= 1'b0;
					pend_valid_q <= 1'b0;
					if (start && !ignore_refresh) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (is_check) begin
						if (hit_go) begin
							valid_q[idx_s1] <= 1'b0;
							cnt_q           <= cnt_q + kwtt_pkg::CNT_W'(1);
							pend_valid_q    <= 1'b1;
							strobe_q        <= pend_valid_q;
						end
						if (cap_full || scan_end) begin
							state_q <= ST_FLUSH;
						end
					end else begin
						if (eval_go && flags.free) begin
							free_found_q <= 1'b1;
						end
						if (match_go) begin
							state_q <= ST_WRITE;
						end else if (scan_end) begin
							state_q <= (free_found_q || flags.free) ? ST_WRITE : ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					strobe_q     <= pend_valid_q;
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				ST_WRITE: begin
					valid_q[tgt_q] <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = rsp_q;

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> (state_q == ST_IDLE))
		else $error("last result while item still in progress");

	a_result_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(cmd_q.func) == kwtt_pkg::FUNC_CHECK))
		else $error("result produced by a refresh item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= kwtt_pkg::CNT_W'(kwtt_pkg::MAX_RESULTS))
		else $error("result count above limit");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held-back result left over at idle");

	a_write_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (state_q == ST_IDLE))
		else $error("entry write not followed by idle");

endmodule

// ===== tb/keyed_watchdog_timeout_table_checker.sv =====
// Checker: mirrors the watchdog table from accepted items and compares expiry results.
`timescale 1ns / 100ps
module keyed_watchdog_timeout_table_checker #(
	parameter int NUM_ENTRIES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  kwtt_pkg::cmd_t command,
	input  logic           strobe,
	input  kwtt_pkg::rsp_t result,
	output int             errors,
	output int             outstanding,
	output int             expiries_seen
);

	logic           slot_valid    [NUM_ENTRIES];
	logic [63:0]    slot_key      [NUM_ENTRIES];
	logic [31:0]    slot_deadline [NUM_ENTRIES];
	logic [15:0]    slot_watts    [NUM_ENTRIES];
	kwtt_pkg::rsp_t due_expiries  [$];
	kwtt_pkg::rsp_t oldest;

	initial begin
		errors = 0;
		outstanding = 0;
		expiries_seen = 0;
	end

	// wrap-safe: passed when now - deadline is positive as a signed 32-bit value
	function automatic logic deadline_passed(logic [31:0] now, logic [31:0] deadline);
		logic [31:0] lag;
		lag = now - deadline;
		return (lag != 32'd0) && !lag[31];
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic rearm_entry(kwtt_pkg::cmd_t c);
		int slot;
		slot = -1;
		if (c.serial == '0 || c.timeout_ms == '0)
			return;
		for (int i = 0; i < NUM_ENTRIES; i++)
			if (slot < 0 && slot_valid[i] && slot_key[i] == c.serial)
				slot = i;
		for (int i = 0; i < NUM_ENTRIES; i++)
			if (slot < 0 && !slot_valid[i])
				slot = i;
		// table full: new serial dropped
		if (slot < 0)
			return;
		slot_valid[slot]    = 1'b1;
		slot_key[slot]      = c.serial;
		slot_deadline[slot] = c.now_ms + c.timeout_ms;
		slot_watts[slot]    = c.limit_watts;
	endtask

	task automatic collect_expiries(kwtt_pkg::cmd_t c);
		int found;
		kwtt_pkg::rsp_t r;
		found = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (found < kwtt_pkg::MAX_RESULTS && slot_valid[i] &&
					deadline_passed(c.now_ms, slot_deadline[i])) begin
				r.expired_serial = slot_key[i];
				r.fallback_watts = slot_watts[i];
				r.last           = 1'b0;
				due_expiries.push_back(r);
				slot_valid[i] = 1'b0;
				found++;
			end
		end
		if (found > 0) begin
			r = due_expiries.pop_back();
			r.last = 1'b1;
			due_expiries.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++)
				slot_valid[i] = 1'b0;
			due_expiries.delete();
		end else begin
			// results first: an item taken at this edge cannot have produced one yet
			if (strobe) begin
				if (due_expiries.size() == 0) begin
					report_mismatch("unexpected result serial", result.expired_serial, '0);
				end else begin
					oldest = due_expiries.pop_front();
					expiries_seen++;
					if (result.expired_serial !== oldest.expired_serial)
						report_mismatch("expired_serial", result.expired_serial,
							oldest.expired_serial);
					if (result.fallback_watts !== oldest.fallback_watts)
						report_mismatch("fallback_watts", 64'(result.fallback_watts),
							64'(oldest.fallback_watts));
					if (result.last !== oldest.last)
						report_mismatch("last", 64'(result.last), 64'(oldest.last));
				end
			end
			if (start && !busy) begin
				if (command.func == kwtt_pkg::FUNC_REFRESH)
					rearm_entry(command);
				else
					collect_expiries(command);
			end
		end
		outstanding = due_expiries.size();
	end

endmodule

// ===== tb/keyed_watchdog_timeout_table_unit_test.sv =====
// Testbench top: stimulus, stall watchdog and verdict for the watchdog timeout table.
`timescale 1ns / 100ps
module keyed_watchdog_timeout_table_unit_test;

	localparam int NUM_ENTRIES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int POOL_SIZE   = 12;
	localparam int LIVE_TARGET = 140;
	localparam int QUIET_TAIL  = 110;
	localparam logic [31:0] NEAR_WRAP = 32'hFFFF_FFF0;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic strobe;
	kwtt_pkg::cmd_t command;
	kwtt_pkg::rsp_t result;

	int errors;
	int outstanding;
	int expiries_seen;
	int stall_cycles;
	int refreshes;
	int checks;
	int ignored_items;
	int live_items;
	int burst_switch;
	int drained_at;
	int roll;
	logic [63:0]    device_pool [POOL_SIZE];
	logic [31:0]    clock_ms;
	logic [31:0]    period;
	logic           idle_bursts;
	kwtt_pkg::cmd_t item;

	keyed_watchdog_timeout_table_unit #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.strobe(strobe),
		.result(result)
	);

	keyed_watchdog_timeout_table_checker #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) expiry_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.strobe(strobe),
		.result(result),
		.errors(errors),
		.outstanding(outstanding),
		.expiries_seen(expiries_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ends the run when neither an item nor a result moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("keyed_watchdog_timeout_table_unit_test: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic kwtt_pkg::cmd_t refresh_of(logic [63:0] serial, logic [31:0] now,
			logic [31:0] timeout, logic [15:0] watts);
		kwtt_pkg::cmd_t c;
		c.func        = kwtt_pkg::FUNC_REFRESH;
		c.serial      = serial;
		c.now_ms      = now;
		c.timeout_ms  = timeout;
		c.limit_watts = watts;
		return c;
	endfunction

	// unused fields of a check carry noise
	function automatic kwtt_pkg::cmd_t check_at(logic [31:0] now);
		kwtt_pkg::cmd_t c;
		c.func        = kwtt_pkg::FUNC_CHECK;
		c.serial      = {$urandom, $urandom};
		c.now_ms      = now;
		c.timeout_ms  = $urandom;
		c.limit_watts = 16'($urandom);
		return c;
	endfunction

	function automatic logic ignored(kwtt_pkg::cmd_t c);
		return c.func == kwtt_pkg::FUNC_REFRESH && (c.serial == '0 || c.timeout_ms == '0);
	endfunction

	// called at a falling edge; returns at the falling edge after the item is taken,
	// with start still high so a following item can go back to back
	task automatic issue(kwtt_pkg::cmd_t c);
		if (c.func == kwtt_pkg::FUNC_CHECK)
			checks++;
		else if (ignored(c))
			ignored_items++;
		else
			refreshes++;
		start   <= 1'b1;
		command <= c;
		while (busy !== 1'b0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		refreshes = 0;
		checks = 0;
		ignored_items = 0;
		live_items = 0;
		drained_at = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, ignored refreshes, fill, full-table drop, re-arm
		issue(check_at(32'd0));
		issue(refresh_of(64'd0, NEAR_WRAP, 32'd100, 16'hFFFF));
		issue(refresh_of('1, NEAR_WRAP, 32'd0, 16'hFFFF));
		issue(refresh_of('1, NEAR_WRAP, 32'h20, 16'hFFFF));
		issue(refresh_of(64'd1, NEAR_WRAP, 32'h20, 16'h0000));
		for (int k = 2; k < NUM_ENTRIES; k++)
			issue(refresh_of(64'(k), NEAR_WRAP, 32'h20, 16'($urandom)));
		issue(refresh_of(64'd3, 32'hFFFF_FFF8, 32'h18, 16'($urandom)));
		issue(refresh_of(64'd8, NEAR_WRAP, 32'h20, 16'($urandom)));
		// deadline equal to now is not yet expired; one tick later all eight go
		issue(check_at(32'h10));
		issue(check_at(32'h11));
		// signed boundary: a lag of 2^31 is not expired, 2^31 - 1 is
		issue(refresh_of(64'hA5A5_5A5A_0F0F_F0F0, 32'h11, 32'h8000_0000, 16'($urandom)));
		issue(refresh_of(64'h5A5A_A5A5_F0F0_0F0F, 32'h11, 32'h1, 16'($urandom)));
		issue(check_at(32'h8000_0012));
		issue(check_at(32'h8000_0011));
		issue(check_at(32'hFFFF_FFFF));
		issue(refresh_of(64'h8000_0000_0000_0000, 32'd0, 32'hFFFF_FFFF, 16'($urandom)));
		issue(check_at(32'd0));
		wait_drained();

		for (int i = 0; i < POOL_SIZE; i++) begin
			device_pool[i] = {$urandom, $urandom};
			if (device_pool[i] == '0)
				device_pool[i] = 64'(i + 1);
		end
		clock_ms = $urandom;
		idle_bursts = 1'b1;
		burst_switch = $urandom_range(8, 30);

		while (live_items < LIVE_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				case ($urandom_range(0, 39))
					0:       period = 32'h7FFF_FFFF;
					1:       period = $urandom;
					default: period = $urandom_range(1, 60);
				endcase
				item = refresh_of(device_pool[$urandom_range(0, POOL_SIZE - 1)], clock_ms,
					period, 16'($urandom));
			end else if (roll < 85) begin
				clock_ms = clock_ms + $urandom_range(0, 40);
				item = check_at(clock_ms);
			end else if (roll < 92) begin
				if ($urandom_range(0, 1))
					item = refresh_of(64'd0, clock_ms, $urandom, 16'($urandom));
				else
					item = refresh_of(device_pool[$urandom_range(0, POOL_SIZE - 1)], clock_ms,
						32'd0, 16'($urandom));
			end else if (roll < 96) begin
				item = refresh_of({$urandom, $urandom}, clock_ms, $urandom_range(1, 60),
					16'($urandom));
			end else begin
				// time jump releases entries parked far in the future
				clock_ms = $urandom;
				item = check_at(clock_ms);
			end
			issue(item);
			if (!ignored(item))
				live_items++;

			if (live_items >= burst_switch) begin
				idle_bursts = !idle_bursts;
				burst_switch = live_items + $urandom_range(8, 30);
			end
			if (live_items % 50 == 0 && live_items != drained_at) begin
				drained_at = live_items;
				wait_drained();
			end else if (idle_bursts && live_items < QUIET_TAIL && $urandom_range(0, 2) == 0) begin
				hold_off($urandom_range(1, 14));
			end
		end

		wait_drained();
		repeat (NUM_ENTRIES + 4) @(negedge clk);
		$display("run covered %0d refreshes, %0d checks and %0d ignored refreshes",
			refreshes, checks, ignored_items);
		$display("with %0d expiries seen, including full-table drops and wrap boundaries",
			expiries_seen);
		if (errors == 0 && outstanding == 0)
			$display("keyed_watchdog_timeout_table_unit_test: clean");
		else
			$display("keyed_watchdog_timeout_table_unit_test: errors");
		$finish;
	end

endmodule
